// ===== rtl/jts_pkg.sv =====
// shared types, codes and keyword tables of the json token scanner
`default_nettype none

package jts_pkg;

   typedef logic [3:0]  kind_type;
   typedef logic [2:0]  err_type;
   typedef logic [1:0]  kwsel_type;

   // token kinds
   localparam kind_type KIND_LBRACE    = 4'd0;
   localparam kind_type KIND_RBRACE    = 4'd1;
   localparam kind_type KIND_COMMA     = 4'd2;
   localparam kind_type KIND_LBRACKET  = 4'd3;
   localparam kind_type KIND_RBRACKET  = 4'd4;
   localparam kind_type KIND_COLON     = 4'd5;
   localparam kind_type KIND_TRUE      = 4'd6;
   localparam kind_type KIND_NUMBER    = 4'd9;
   localparam kind_type KIND_STR_START = 4'd10;
   localparam kind_type KIND_STR_CHAR  = 4'd11;
   localparam kind_type KIND_STR_END   = 4'd12;
   localparam kind_type KIND_ERROR     = 4'd13;
   localparam kind_type KIND_DONE      = 4'd14;

   // error codes
   localparam err_type ERR_NONE        = 3'd0;
   localparam err_type ERR_UNEXPECTED  = 3'd1;
   localparam err_type ERR_UNTERMINATED = 3'd2;
   localparam err_type ERR_BAD_DOT     = 3'd3;
   localparam err_type ERR_OVERFLOW    = 3'd4;

   // keyword selects
   localparam kwsel_type KW_TRUE  = 2'd0;
   localparam kwsel_type KW_FALSE = 2'd1;
   localparam kwsel_type KW_NULL  = 2'd2;

   // characters
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COLON    = 8'h3A;

   localparam logic [4:0] MAX_FRAC = 5'd20;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   typedef struct packed {
      logic        last_result;
      err_type     error_code;
      logic [7:0]  string_char;
      logic [4:0]  fraction_digits;
      logic [63:0] mantissa;
      logic [31:0] position;
      kind_type    kind;
   } result_type;

   // results of one byte, in order, with how many are valid
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] item;
   } batch_type;

   function automatic logic [7:0] kw_char(input kwsel_type sel, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (sel)
         KW_FALSE: begin
            case (idx)
               3'd0: c = 8'h66;
               3'd1: c = 8'h61;
               3'd2: c = 8'h6C;
               3'd3: c = 8'h73;
               3'd4: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
         KW_NULL: begin
            case (idx)
               3'd0: c = 8'h6E;
               3'd1: c = 8'h75;
               3'd2: c = 8'h6C;
               3'd3: c = 8'h6C;
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0: c = 8'h74;
               3'd1: c = 8'h72;
               3'd2: c = 8'h75;
               3'd3: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic logic [2:0] kw_len(input kwsel_type sel);
      logic [2:0] n;
      case (sel)
         KW_FALSE: n = 3'd5;
         default:  n = 3'd4;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/jts_scan.sv =====
// byte register and per-byte scanner state machine producing up to three tokens
`default_nettype none

module jts_scan #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   input  wire logic              room,
   output      jts_pkg::batch_type batch
);
   import jts_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_STRING,
      MODE_KEYWORD,
      MODE_ERROR
   } mode_type;

   logic                     hold_ff;
   logic [7:0]               byte_ff;
   logic                     last_ff;
   logic                     step;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] offset_ff, offset_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [63:0]              acc_ff, acc_in;
   logic [4:0]               frac_ff, frac_in;
   logic                     dot_ff, dot_in;
   kwsel_type                ksel_ff, ksel_in;
   logic [2:0]               kidx_ff, kidx_in;

   logic                     is_digit, is_dot;
   logic [3:0]               digit;
   logic [67:0]              wide;
   logic                     ovf;
   kwsel_type                ksel_eff;
   logic                     rescan;
   logic [1:0]               cnt;
   result_type [MAX_RESULTS-1:0] res;

   function automatic result_type mk(input kind_type k, input logic [POSITION_BITS-1:0] p,
                                     input logic [63:0] m, input logic [4:0] f,
                                     input logic [7:0] c, input err_type e);
      result_type r;
      r.kind            = k;
      r.position        = 32'(p);
      r.mantissa        = m;
      r.fraction_digits = f;
      r.string_char     = c;
      r.error_code      = e;
      r.last_result     = 1'b0;
      return r;
   endfunction

   assign step     = hold_ff && room;
   assign in_ready = !hold_ff || room;

   assign is_digit = byte_ff inside {[CH_ZERO:CH_NINE]};
   assign is_dot   = (byte_ff == CH_DOT);
   assign digit    = 4'(byte_ff - CH_ZERO);
   // acc * 10 + digit, top bits flag a 64 bit overflow
   assign wide     = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + 68'(digit);
   assign ovf      = (|wide[67:64]) || (dot_ff && (frac_ff >= MAX_FRAC));
   assign ksel_eff = (ksel_ff > KW_NULL) ? KW_TRUE : ksel_ff;

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      start_in  = start_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      dot_in    = dot_ff;
      ksel_in   = ksel_ff;
      kidx_in   = kidx_ff;
      rescan    = 1'b0;
      cnt       = '0;
      res       = '0;

      if (step) begin
         case (mode_ff)
            MODE_IDLE: rescan = 1'b1;
            MODE_NUMBER: begin
               if (is_digit) begin
                  if (ovf) begin
                     res[cnt] = mk(KIND_ERROR, start_ff, '0, '0, '0, ERR_OVERFLOW);
                     cnt      = cnt + 2'd1;
                     mode_in  = MODE_ERROR;
                  end else begin
                     acc_in = wide[63:0];
                     if (dot_ff) frac_in = frac_ff + 5'd1;
                  end
               end else if (is_dot && !dot_ff) begin
                  dot_in = 1'b1;
               end else if (dot_ff && (frac_ff == '0)) begin
                  // dot with no digit after it, ending byte dropped
                  res[cnt] = mk(KIND_ERROR, start_ff, '0, '0, '0, ERR_BAD_DOT);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_ERROR;
               end else begin
                  res[cnt] = mk(KIND_NUMBER, start_ff, acc_ff, frac_ff, '0, ERR_NONE);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_IDLE;
                  rescan   = 1'b1;
               end
            end
            MODE_STRING: begin
               if (byte_ff == CH_QUOTE) begin
                  res[cnt] = mk(KIND_STR_END, offset_ff, '0, '0, '0, ERR_NONE);
                  mode_in  = MODE_IDLE;
               end else begin
                  res[cnt] = mk(KIND_STR_CHAR, offset_ff, '0, '0, byte_ff, ERR_NONE);
               end
               cnt = cnt + 2'd1;
            end
            MODE_KEYWORD: begin
               if ((kidx_ff >= kw_len(ksel_eff)) || (byte_ff != kw_char(ksel_eff, kidx_ff)))
               begin
                  res[cnt] = mk(KIND_ERROR, start_ff, '0, '0, '0, ERR_UNEXPECTED);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_ERROR;
               end else begin
                  kidx_in = kidx_ff + 3'd1;
                  if (kidx_in == kw_len(ksel_eff)) begin
                     res[cnt] = mk(kind_type'(KIND_TRUE + kind_type'(ksel_eff)), start_ff,
                                   '0, '0, '0, ERR_NONE);
                     cnt      = cnt + 2'd1;
                     mode_in  = MODE_IDLE;
                  end
               end
            end
            default: mode_in = MODE_ERROR;
         endcase

         if (rescan) begin
            case (byte_ff)
               CH_SPACE, CH_NEWLINE: begin
               end
               CH_LBRACE: begin
                  res[cnt] = mk(KIND_LBRACE, offset_ff, '0, '0, '0, ERR_NONE);
                  cnt      = cnt + 2'd1;
               end
               CH_RBRACE: begin
                  res[cnt] = mk(KIND_RBRACE, offset_ff, '0, '0, '0, ERR_NONE);
                  cnt      = cnt + 2'd1;
               end
               CH_COMMA: begin
                  res[cnt] = mk(KIND_COMMA, offset_ff, '0, '0, '0, ERR_NONE);
                  cnt      = cnt + 2'd1;
               end
               CH_LBRACKET: begin
                  res[cnt] = mk(KIND_LBRACKET, offset_ff, '0, '0, '0, ERR_NONE);
                  cnt      = cnt + 2'd1;
               end
               CH_RBRACKET: begin
                  res[cnt] = mk(KIND_RBRACKET, offset_ff, '0, '0, '0, ERR_NONE);
                  cnt      = cnt + 2'd1;
               end
               CH_COLON: begin
                  res[cnt] = mk(KIND_COLON, offset_ff, '0, '0, '0, ERR_NONE);
                  cnt      = cnt + 2'd1;
               end
               CH_QUOTE: begin
                  start_in = offset_ff;
                  // a quote as the final byte gives no start token, only the error and the done token
                  if (!last_ff) begin
                     res[cnt] = mk(KIND_STR_START, offset_ff, '0, '0, '0, ERR_NONE);
                     cnt      = cnt + 2'd1;
                  end
                  mode_in = MODE_STRING;
               end
               default: begin
                  start_in = offset_ff;
                  if (is_digit || is_dot) begin
                     mode_in = MODE_NUMBER;
                     acc_in  = is_dot ? 64'd0 : 64'(digit);
                     frac_in = '0;
                     dot_in  = is_dot;
                  end else if (byte_ff == kw_char(KW_TRUE, 3'd0)) begin
                     mode_in = MODE_KEYWORD;
                     ksel_in = KW_TRUE;
                     kidx_in = 3'd1;
                  end else if (byte_ff == kw_char(KW_FALSE, 3'd0)) begin
                     mode_in = MODE_KEYWORD;
                     ksel_in = KW_FALSE;
                     kidx_in = 3'd1;
                  end else if (byte_ff == kw_char(KW_NULL, 3'd0)) begin
                     mode_in = MODE_KEYWORD;
                     ksel_in = KW_NULL;
                     kidx_in = 3'd1;
                  end else begin
                     res[cnt] = mk(KIND_ERROR, offset_ff, '0, '0, '0, ERR_UNEXPECTED);
                     cnt      = cnt + 2'd1;
                     mode_in  = MODE_ERROR;
                  end
               end
            endcase
         end

         if (last_ff) begin
            // close whatever is still open, then done and back to reset
            case (mode_in)
               MODE_NUMBER: begin
                  if (dot_in && (frac_in == '0)) begin
                     res[cnt] = mk(KIND_ERROR, start_in, '0, '0, '0, ERR_BAD_DOT);
                  end else begin
                     res[cnt] = mk(KIND_NUMBER, start_in, acc_in, frac_in, '0, ERR_NONE);
                  end
                  cnt = cnt + 2'd1;
               end
               MODE_STRING: begin
                  res[cnt] = mk(KIND_ERROR, start_in, '0, '0, '0, ERR_UNTERMINATED);
                  cnt      = cnt + 2'd1;
               end
               MODE_KEYWORD: begin
                  res[cnt] = mk(KIND_ERROR, start_in, '0, '0, '0, ERR_UNEXPECTED);
                  cnt      = cnt + 2'd1;
               end
               default: begin
               end
            endcase
            res[cnt]  = mk(KIND_DONE, offset_ff, '0, '0, '0, ERR_NONE);
            cnt       = cnt + 2'd1;
            mode_in   = MODE_IDLE;
            offset_in = '0;
            start_in  = '0;
            acc_in    = '0;
            frac_in   = '0;
            dot_in    = 1'b0;
            ksel_in   = KW_TRUE;
            kidx_in   = '0;
         end else begin
            offset_in = offset_ff + POSITION_BITS'(1);
         end
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         if ((cnt != 2'd0) && (2'(i) == (cnt - 2'd1))) res[i].last_result = 1'b1;
      end
      batch.count = cnt;
      batch.item  = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else if (in_ready) begin
         hold_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         start_ff  <= '0;
         acc_ff    <= '0;
         frac_ff   <= '0;
         dot_ff    <= 1'b0;
         ksel_ff   <= KW_TRUE;
         kidx_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
         acc_ff    <= acc_in;
         frac_ff   <= frac_in;
         dot_ff    <= dot_in;
         ksel_ff   <= ksel_in;
         kidx_ff   <= kidx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/jts_queue.sv =====
// four-entry token queue taking up to three tokens a cycle and giving one while out_ready is high
`default_nettype none

module jts_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jts_pkg::batch_type batch,
   output      logic               room,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      jts_pkg::result_type out_item
);
   import jts_pkg::*;

   result_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));

   assign wr_ptr_in = wr_ptr_ff + QPTR_BITS'(batch.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
   assign count_in  = count_ff + QCNT_BITS'(batch.count) - QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < batch.count) begin
            mem_ff[wr_ptr_ff + QPTR_BITS'(i)] <= batch.item[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/json_token_scanner_unit.sv =====
// top level of the streaming json token scanner
`default_nettype none

// channel  dir  tdata                                   tuser       tlast
// req      in   [7:0] text_byte                         -           end_of_text
// rsp      out  [31:0] token_position, [95:32] mantissa, [3:0] kind  last_result
//               [100:96] fraction_digits,
//               [108:101] string_char, [111:109] error_code
//
// one text byte per cycle sustained while the result queue has room; a byte is
// registered and scanned, and its zero to three tokens land in a four-entry result queue
// the first token of a byte is written to the queue memory from the byte register and leaves from there
// a byte that yields two or three tokens holds off input until the queue
// drains, one token per cycle through the single output port while rsp_tready is high
// synchronous active-high reset returns the scanner to idle at offset zero
module json_token_scanner_unit #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] text_byte
   input  wire logic         req_tlast,   // end_of_text
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [111:0] rsp_tdata,   // token_position, mantissa, fraction_digits,
                                          // string_char, error_code
   output      logic [3:0]   rsp_tuser,   // token_kind
   output      logic         rsp_tlast    // last_result
);
   import jts_pkg::*;

   batch_type  batch;
   logic       room;
   result_type head;

   // scanner: byte register plus mode state, emits a batch of tokens per byte
   jts_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .room     (room),
      .batch    (batch)
   );

   // result queue parts the scanner from a stalled consumer
   jts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   // pack the head token, first field in the lowest bits
   assign rsp_tdata = {head.error_code, head.string_char, head.fraction_digits,
                       head.mantissa, head.position};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_result;

endmodule

`default_nettype wire

// ===== sim/json_token_scanner_unit_tb.sv =====
// self-checking testbench of the json token scanner: directed table, then random json texts
module json_token_scanner_unit_tb;
   import jts_pkg::*;

   localparam int LIVE_ITEMS     = 325;   // random bytes offered after the directed table
   localparam int HOLD_CYCLES    = 96;    // one long receiver hold-off
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_NUMBER, SCAN_STRING, SCAN_KEYWORD, SCAN_ERROR
   } scan_state_type;

   // one directed byte; pinned rows carry their single token typed in
   typedef struct packed {
      logic [7:0]  text;
      logic        final_byte;
      logic        pinned;
      kind_type    kind;
      logic [31:0] position;
      err_type     err;
   } directed_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         rsp_tlast;

   // scanner state as predicted
   scan_state_type scan_state;
   logic [31:0]    next_offset;
   logic [31:0]    start_offset;
   logic [63:0]    digits;
   logic [4:0]     frac_seen;
   logic           dot_flag;
   kwsel_type      kw_pick;
   logic [2:0]     kw_matched;

   result_type  step_tokens[$];
   result_type  expected_tokens[$];
   logic [7:0]  text_bytes[$];
   result_type  token_seen;
   result_type  token_wanted;

   int   mismatches;
   int   live_items;
   int   idle_cycles;
   logic calm;
   logic hold_request;

   directed_row_type script [25] = '{
      '{CH_LBRACE,   1'b0, 1'b1, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{CH_QUOTE,    1'b0, 1'b1, KIND_STR_START, 32'd1,  ERR_NONE},
      '{8'hFF,       1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{8'h00,       1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{CH_QUOTE,    1'b0, 1'b1, KIND_STR_END,   32'd4,  ERR_NONE},
      '{CH_NEWLINE,  1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{CH_DOT,      1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"5",         1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      // second dot closes .5 and opens a lone dot
      '{CH_DOT,      1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{CH_SPACE,    1'b0, 1'b1, KIND_ERROR,     32'd8,  ERR_BAD_DOT},
      '{"x",         1'b1, 1'b1, KIND_DONE,      32'd10, ERR_NONE},
      '{"f",         1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"a",         1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"l",         1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"s",         1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"e",         1'b0, 1'b1, KIND_TRUE + KW_FALSE, 32'd0, ERR_NONE},
      '{CH_COLON,    1'b0, 1'b1, KIND_COLON,     32'd5,  ERR_NONE},
      '{"n",         1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"u",         1'b0, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"x",         1'b0, 1'b1, KIND_ERROR,     32'd6,  ERR_UNEXPECTED},
      '{"9",         1'b1, 1'b1, KIND_DONE,      32'd9,  ERR_NONE},
      // single-byte texts: stray byte, lone quote, open number, open keyword
      '{"@",         1'b1, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{CH_QUOTE,    1'b1, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"7",         1'b1, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE},
      '{"t",         1'b1, 1'b0, KIND_LBRACE,    32'd0,  ERR_NONE}
   };

   json_token_scanner_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic string keyword_word(input kwsel_type sel);
      case (sel)
         KW_FALSE: return "false";
         KW_NULL:  return "null";
         default:  return "true";
      endcase
   endfunction

   // ---------------- token predictor ----------------

   task automatic clear_scanner();
      scan_state   = SCAN_IDLE;
      next_offset  = '0;
      start_offset = '0;
      digits       = '0;
      frac_seen    = '0;
      dot_flag     = 1'b0;
      kw_pick      = KW_TRUE;
      kw_matched   = '0;
   endtask

   task automatic add_token(input kind_type kind, input logic [31:0] pos,
                            input logic [63:0] mant, input logic [4:0] frac,
                            input logic [7:0] ch, input err_type err);
      result_type t;
      if (step_tokens.size() < MAX_RESULTS) begin
         t = '0;
         t.kind            = kind;
         t.position        = pos;
         t.mantissa        = mant;
         t.fraction_digits = frac;
         t.string_char     = ch;
         t.error_code      = err;
         step_tokens.push_back(t);
      end
   endtask

   task automatic enter_error(input logic [31:0] pos, input err_type err);
      add_token(KIND_ERROR, pos, '0, '0, '0, err);
      scan_state = SCAN_ERROR;
   endtask

   task automatic close_number(output logic ok);
      if (dot_flag && frac_seen == 5'd0) begin
         enter_error(start_offset, ERR_BAD_DOT);
         ok = 1'b0;
      end else begin
         add_token(KIND_NUMBER, start_offset, digits, frac_seen, '0, ERR_NONE);
         scan_state = SCAN_IDLE;
         ok = 1'b1;
      end
   endtask

   // byte seen between tokens
   task automatic scan_fresh(input logic [7:0] b, input logic [31:0] pos,
                             input logic final_byte);
      int    k;
      logic  matched;
      string word;
      case (b)
         CH_SPACE, CH_NEWLINE: begin
         end
         CH_LBRACE:   add_token(KIND_LBRACE,   pos, '0, '0, '0, ERR_NONE);
         CH_RBRACE:   add_token(KIND_RBRACE,   pos, '0, '0, '0, ERR_NONE);
         CH_COMMA:    add_token(KIND_COMMA,    pos, '0, '0, '0, ERR_NONE);
         CH_LBRACKET: add_token(KIND_LBRACKET, pos, '0, '0, '0, ERR_NONE);
         CH_RBRACKET: add_token(KIND_RBRACKET, pos, '0, '0, '0, ERR_NONE);
         CH_COLON:    add_token(KIND_COLON,    pos, '0, '0, '0, ERR_NONE);
         default: begin
            start_offset = pos;
            if (b == CH_QUOTE) begin
               // a quote as the final byte opens no string token
               if (!final_byte) add_token(KIND_STR_START, pos, '0, '0, '0, ERR_NONE);
               scan_state = SCAN_STRING;
            end else if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT) begin
               scan_state = SCAN_NUMBER;
               digits     = (b == CH_DOT) ? 64'd0 : 64'(b) - 64'(CH_ZERO);
               frac_seen  = '0;
               dot_flag   = (b == CH_DOT);
            end else begin
               matched = 1'b0;
               for (k = 0; k < 3; k++) begin
                  word = keyword_word(kwsel_type'(k));
                  if (!matched && b == word[0]) begin
                     matched    = 1'b1;
                     scan_state = SCAN_KEYWORD;
                     kw_pick    = kwsel_type'(k);
                     kw_matched = 3'd1;
                  end
               end
               if (!matched) enter_error(pos, ERR_UNEXPECTED);
            end
         end
      endcase
   endtask

   task automatic scan_number_byte(input logic [7:0] b, input logic [31:0] pos,
                                   input logic final_byte);
      logic [63:0] d;
      logic        ok;
      if (b >= CH_ZERO && b <= CH_NINE) begin
         d = 64'(b) - 64'(CH_ZERO);
         if (digits > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10 ||
             (dot_flag && frac_seen >= MAX_FRAC)) begin
            enter_error(start_offset, ERR_OVERFLOW);
         end else begin
            digits = digits * 64'd10 + d;
            if (dot_flag) frac_seen = frac_seen + 5'd1;
         end
      end else if (b == CH_DOT && !dot_flag) begin
         dot_flag = 1'b1;
      end else begin
         // the ending byte is scanned again unless the number was bad
         close_number(ok);
         if (ok) scan_fresh(b, pos, final_byte);
      end
   endtask

   task automatic scan_keyword_byte(input logic [7:0] b);
      string word;
      word = keyword_word(kw_pick);
      if (kw_matched >= word.len() || b != word[kw_matched]) begin
         enter_error(start_offset, ERR_UNEXPECTED);
      end else begin
         kw_matched = kw_matched + 3'd1;
         if (kw_matched == word.len()) begin
            add_token(kind_type'(KIND_TRUE + kw_pick), start_offset, '0, '0, '0, ERR_NONE);
            scan_state = SCAN_IDLE;
         end
      end
   endtask

   // tokens caused by one accepted byte, left in step_tokens
   task automatic predict_byte(input logic [7:0] b, input logic final_byte);
      logic [31:0] pos;
      logic        ok;
      result_type  t;
      step_tokens.delete();
      pos = next_offset;
      case (scan_state)
         SCAN_IDLE:   scan_fresh(b, pos, final_byte);
         SCAN_NUMBER: scan_number_byte(b, pos, final_byte);
         SCAN_STRING: begin
            if (b == CH_QUOTE) begin
               add_token(KIND_STR_END, pos, '0, '0, '0, ERR_NONE);
               scan_state = SCAN_IDLE;
            end else begin
               add_token(KIND_STR_CHAR, pos, '0, '0, b, ERR_NONE);
            end
         end
         SCAN_KEYWORD: scan_keyword_byte(b);
         default: begin
         end
      endcase
      if (final_byte) begin
         case (scan_state)
            SCAN_NUMBER:  close_number(ok);
            SCAN_STRING:  enter_error(start_offset, ERR_UNTERMINATED);
            SCAN_KEYWORD: enter_error(start_offset, ERR_UNEXPECTED);
            default: begin
            end
         endcase
         add_token(KIND_DONE, pos, '0, '0, '0, ERR_NONE);
         clear_scanner();
      end else begin
         next_offset = next_offset + 32'd1;
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last_result = 1'b1;
         step_tokens.push_back(t);
      end
   endtask

   // ---------------- stimulus ----------------

   // drive one byte, wait for its handshake, then book its tokens
   task automatic offer(input logic [7:0] b, input logic final_byte,
                        input logic pinned, input result_type pinned_token);
      int gap;
      int k;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= final_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      live_items++;
      predict_byte(b, final_byte);
      if (pinned) begin
         step_tokens.delete();
         step_tokens.push_back(pinned_token);
      end
      for (k = 0; k < step_tokens.size(); k++) expected_tokens.push_back(step_tokens[k]);
   endtask

   task automatic push_word(input string word);
      int k;
      for (k = 0; k < word.len(); k++) text_bytes.push_back(word[k]);
   endtask

   task automatic compose_number();
      int pick;
      int k;
      int int_len;
      int frac_len;
      logic with_dot;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // largest mantissa, or one past it
         push_word($urandom_range(0, 1) ? "18446744073709551615" : "18446744073709551616");
      end else if (pick == 1) begin
         // twenty fraction digits fit, twenty-one overflow
         text_bytes.push_back(CH_DOT);
         frac_len = $urandom_range(19, 20);
         for (k = 0; k < frac_len; k++) text_bytes.push_back(CH_ZERO);
         text_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end else begin
         int_len  = $urandom_range(0, 5);
         with_dot = 1'($urandom_range(0, 1));
         frac_len = with_dot ? $urandom_range(0, 4) : 0;
         if (int_len == 0 && !with_dot) int_len = 1;
         for (k = 0; k < int_len; k++) text_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         if (with_dot) text_bytes.push_back(CH_DOT);
         for (k = 0; k < frac_len; k++) text_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
   endtask

   // one random text, mostly well formed, with some noise and broken pieces
   task automatic compose_text();
      int        pieces;
      int        p;
      int        k;
      int        n;
      int        choice;
      kwsel_type sel;
      string     word;
      logic [7:0] ch;
      text_bytes.delete();
      pieces = $urandom_range(1, 8);
      for (p = 0; p < pieces; p++) begin
         choice = $urandom_range(0, 99);
         if (choice < 20) begin
            case ($urandom_range(0, 5))
               0: text_bytes.push_back(CH_LBRACE);
               1: text_bytes.push_back(CH_RBRACE);
               2: text_bytes.push_back(CH_COMMA);
               3: text_bytes.push_back(CH_LBRACKET);
               4: text_bytes.push_back(CH_RBRACKET);
               default: text_bytes.push_back(CH_COLON);
            endcase
         end else if (choice < 30) begin
            text_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
         end else if (choice < 45) begin
            sel  = kwsel_type'($urandom_range(0, 2));
            word = keyword_word(sel);
            n    = word.len();
            if ($urandom_range(0, 9) == 0) n = $urandom_range(1, word.len() - 1);
            for (k = 0; k < n; k++) text_bytes.push_back(word[k]);
            if (n < word.len() && $urandom_range(0, 1)) begin
               text_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end else if (choice < 65) begin
            compose_number();
         end else if (choice < 85) begin
            text_bytes.push_back(CH_QUOTE);
            n = $urandom_range(0, 6);
            for (k = 0; k < n; k++) begin
               ch = 8'($urandom_range(0, 255));
               if (ch == CH_QUOTE) ch = 8'h27;
               text_bytes.push_back(ch);
            end
            // the text may end inside the string
            if (p != pieces - 1 || $urandom_range(0, 3) != 0) text_bytes.push_back(CH_QUOTE);
         end else begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      int         r;
      int         k;
      result_type pinned_token;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tlast    <= 1'b0;
      mismatches   = 0;
      live_items   = 0;
      calm         = 1'b0;
      hold_request = 1'b0;
      clear_scanner();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < 25; r++) begin
         pinned_token                 = '0;
         pinned_token.kind            = script[r].kind;
         pinned_token.position        = script[r].position;
         pinned_token.error_code      = script[r].err;
         pinned_token.last_result     = 1'b1;
         offer(script[r].text, script[r].final_byte, script[r].pinned, pinned_token);
      end

      hold_request = 1'b1;
      live_items   = 0;
      while (live_items < LIVE_ITEMS) begin
         compose_text();
         calm = ($urandom_range(0, 3) == 0);
         for (k = 0; k < text_bytes.size(); k++) begin
            offer(text_bytes[k], k == text_bytes.size() - 1, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("json_token_scanner_unit verification clean");
      end else begin
         $display("json_token_scanner_unit verification failed");
      end
      $finish;
   end

   // ---------------- token receiver ----------------

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 7);
         if (hold_request) begin
            // long hold-off while bytes keep coming, so the result queue backs up
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: token %s expected %0h got %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         token_seen.kind            = rsp_tuser;
         token_seen.position        = rsp_tdata[31:0];
         token_seen.mantissa        = rsp_tdata[95:32];
         token_seen.fraction_digits = rsp_tdata[100:96];
         token_seen.string_char     = rsp_tdata[108:101];
         token_seen.error_code      = rsp_tdata[111:109];
         token_seen.last_result     = rsp_tlast;
         if (expected_tokens.size() == 0) begin
            $display("%0t: token expected none got kind %0h position %0h",
                     $time, token_seen.kind, token_seen.position);
            mismatches++;
         end else begin
            token_wanted = expected_tokens.pop_front();
            check_field("kind", 64'(token_wanted.kind), 64'(token_seen.kind));
            check_field("position", 64'(token_wanted.position), 64'(token_seen.position));
            check_field("mantissa", token_wanted.mantissa, token_seen.mantissa);
            check_field("fraction_digits", 64'(token_wanted.fraction_digits),
                        64'(token_seen.fraction_digits));
            check_field("string_char", 64'(token_wanted.string_char),
                        64'(token_seen.string_char));
            check_field("error_code", 64'(token_wanted.error_code),
                        64'(token_seen.error_code));
            check_field("last_result", 64'(token_wanted.last_result),
                        64'(token_seen.last_result));
         end
      end
   end

   // stuck handshake guard
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("json_token_scanner_unit verification failed");
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
rtl/jts_pkg.sv
rtl/jts_scan.sv
rtl/jts_queue.sv
rtl/json_token_scanner_unit.sv
sim/json_token_scanner_unit_tb.sv
